>>> design/nsa_pkg.sv
// shared types, codes and helpers for the note slot allocator
`timescale 1ns / 1ps
`default_nettype none
package nsa_pkg;

	localparam int SLOT_COUNT_DEF = 16;

	typedef enum logic [2:0] {
		KIND_ALLOC   = 3'd0,
		KIND_RELEASE = 3'd1,
		KIND_REL_ALL = 3'd2,
		KIND_ADVANCE = 3'd3,
		KIND_SET     = 3'd4
	} kind_t;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_ZERO_VEL = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;

	localparam logic signed [31:0] TIME_UNSET = -32'sd1;
	localparam logic signed [31:0] TIME_MAX   = 32'sh7FFF_FFFF;

	typedef struct packed {
		logic [15:0]        vel;
		logic signed [31:0] t_start;
		logic signed [31:0] t_stop;
	} entry_t;

	localparam entry_t ENTRY_RESET = '{vel: 16'd0, t_start: TIME_UNSET, t_stop: TIME_UNSET};

	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic clr_one;
		logic clr_all;
	} tab_ctl_t;

	// t is known to be non-negative here
	function automatic logic signed [31:0] sat_add(input logic signed [31:0] t,
			input logic [15:0] step);
		logic [32:0] sum;
		sum = {1'b0, t} + {17'd0, step};
		if (sum[32] || sum[31]) begin
			return TIME_MAX;
		end
		return signed'(sum[31:0]);
	endfunction

endpackage
`default_nettype wire

>>> design/nsa_slot_tab.sv
// slot table: synchronous memory with separate read and write ports and per-entry valid bits
`timescale 1ns / 1ps
`default_nettype none
module nsa_slot_tab #(
	parameter int SLOT_COUNT = nsa_pkg::SLOT_COUNT_DEF,
	parameter int AW = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire nsa_pkg::tab_ctl_t ctl,
	input  wire logic [AW-1:0]     rd_addr,
	input  wire logic [AW-1:0]     wr_addr,
	input  wire nsa_pkg::entry_t   wr_data,
	output nsa_pkg::entry_t        rd_ent
);
	import nsa_pkg::*;

	entry_t                  mem_q [SLOT_COUNT];
	logic [SLOT_COUNT-1:0]   valid_q;
	entry_t                  rd_s1;
	logic                    rd_valid_s1;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_s1 <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (ctl.clr_all) begin
				valid_q <= '0;
			end else if (ctl.wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end else if (ctl.clr_one) begin
				valid_q[wr_addr] <= 1'b0;
			end
			if (ctl.rd_en) begin
				rd_valid_s1 <= valid_q[rd_addr];
			end
		end
	end

	// entries never written since reset or release read as cleared
	assign rd_ent = rd_valid_s1 ? rd_s1 : ENTRY_RESET;

endmodule
`default_nettype wire

>>> design/note_slot_allocator.sv
// note slot allocator: first-free slot claim, release, release all, time set and time advance over a slot table
// release all, rejected allocates, out-of-range release/set and no-op commands: done in the cycle after accept
// release and set times: one table read of the given slot, then the write-back and done
// allocate: walks the table one slot a cycle from slot 0 and claims the first free slot
// advance: walks every slot, one slot per cycle
// reset clears all valid bits at once, so the table reads as cleared with no sweep
`timescale 1ns / 1ps
`default_nettype none
module note_slot_allocator #(
	parameter int SLOT_COUNT = nsa_pkg::SLOT_COUNT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  kind,
	input  wire logic [15:0] velocity,
	input  wire logic [3:0]  slot,
	input  wire logic [15:0] tick_step,
	input  wire logic signed [31:0] start_time,
	input  wire logic signed [31:0] stop_time,
	output logic             done,
	output logic [1:0]       status,
	output logic [3:0]       slot_given,
	output logic [4:0]       active_count
);
	import nsa_pkg::*;

	localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CW = $clog2(SLOT_COUNT + 1);
	localparam logic [AW-1:0] LAST_ADDR = AW'(SLOT_COUNT - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(SLOT_COUNT);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_RUN  = 2'b10
	} state_t;

	state_t          state_q, state_d;
	kind_t           kind_q;
	logic [15:0]     vel_q;
	logic [15:0]     tstep_q;
	logic signed [31:0] tstart_q, tstop_q;
	logic [AW-1:0]   addr_q, addr_d;
	logic            issue_q, issue_d;
	logic            single_q, single_d;
	logic            rd_vld_s1;
	logic [AW-1:0]   addr_s1;
	logic [CW-1:0]   total_q, total_d;
	logic            done_q, done_d;
	logic [1:0]      status_q, status_d;
	logic [3:0]      given_q, given_d;
	logic            accept, finish, in_range;
	tab_ctl_t        ctl;
	entry_t          wr_data, rd_ent;

	assign busy     = (state_q == S_RUN);
	assign accept   = start && !busy;
	assign in_range = (9'(slot) < 9'(SLOT_COUNT));

	nsa_slot_tab #(
		.SLOT_COUNT(SLOT_COUNT),
		.AW(AW)
	) u_tab (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.rd_addr(addr_q),
		.wr_addr(addr_s1),
		.wr_data(wr_data),
		.rd_ent(rd_ent)
	);

	always_comb begin
		state_d  = state_q;
		total_d  = total_q;
		done_d   = 1'b0;
		status_d = status_q;
		given_d  = given_q;
		addr_d   = addr_q;
		issue_d  = issue_q;
		single_d = single_q;
		finish   = 1'b0;
		ctl      = '0;
		wr_data  = rd_ent;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					status_d = ST_OK;
					given_d  = 4'd0;
					addr_d   = '0;
					issue_d  = 1'b1;
					single_d = 1'b0;
					unique case (kind_t'(kind))
						KIND_ALLOC: begin
							if (velocity == 16'd0) begin
								status_d = ST_ZERO_VEL;
								done_d   = 1'b1;
							end else if (total_q >= FULL_CNT) begin
								status_d = ST_FULL;
								done_d   = 1'b1;
							end else begin
								state_d = S_RUN;
							end
						end
						KIND_RELEASE, KIND_SET: begin
							if (in_range) begin
								state_d  = S_RUN;
								single_d = 1'b1;
								addr_d   = AW'(slot);
							end else begin
								done_d = 1'b1;
							end
						end
						KIND_REL_ALL: begin
							ctl.clr_all = 1'b1;
							total_d     = '0;
							done_d      = 1'b1;
						end
						KIND_ADVANCE: begin
							state_d = S_RUN;
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
				end
			end
			S_RUN: begin
				ctl.rd_en = issue_q;
				if (issue_q) begin
					if (single_q || addr_q == LAST_ADDR) begin
						issue_d = 1'b0;
					end else begin
						addr_d = addr_q + 1'b1;
					end
				end
				if (rd_vld_s1) begin
					unique case (kind_q)
						KIND_ALLOC: begin
							if (rd_ent.vel == 16'd0) begin
								ctl.wr_en   = 1'b1;
								wr_data.vel = vel_q;
								total_d     = total_q + 1'b1;
								given_d     = 4'(addr_s1);
								finish      = 1'b1;
							end else if (addr_s1 == LAST_ADDR) begin
								status_d = ST_FULL;
								finish   = 1'b1;
							end
						end
						KIND_RELEASE: begin
							if (rd_ent.vel != 16'd0 && total_q != '0) begin
								total_d = total_q - 1'b1;
							end
							ctl.clr_one = 1'b1;
							finish      = 1'b1;
						end
						KIND_ADVANCE: begin
							if (rd_ent.vel != 16'd0 && !rd_ent.t_start[31]) begin
								ctl.wr_en       = 1'b1;
								wr_data.t_start = sat_add(rd_ent.t_start, tstep_q);
								if (!rd_ent.t_stop[31]) begin
									wr_data.t_stop = sat_add(rd_ent.t_stop, tstep_q);
								end
							end
							if (addr_s1 == LAST_ADDR) begin
								finish = 1'b1;
							end
						end
						KIND_SET: begin
							ctl.wr_en       = 1'b1;
							wr_data.t_start = tstart_q;
							wr_data.t_stop  = tstop_q;
							finish          = 1'b1;
						end
						default: begin
							finish = 1'b1;
						end
					endcase
				end
				if (finish) begin
					state_d = S_IDLE;
					done_d  = 1'b1;
					issue_d = 1'b0;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			issue_q   <= 1'b0;
			single_q  <= 1'b0;
			rd_vld_s1 <= 1'b0;
			total_q   <= '0;
			done_q    <= 1'b0;
			status_q  <= ST_OK;
			given_q   <= 4'd0;
		end else begin
			state_q   <= state_d;
			issue_q   <= issue_d;
			single_q  <= single_d;
			rd_vld_s1 <= (state_q == S_RUN) && issue_q && !finish;
			total_q   <= total_d;
			done_q    <= done_d;
			status_q  <= status_d;
			given_q   <= given_d;
		end
	end

	always_ff @(posedge clk) begin
		addr_q  <= addr_d;
		addr_s1 <= addr_q;
		if (accept) begin
			kind_q   <= kind_t'(kind);
			vel_q    <= velocity;
			tstep_q  <= tick_step;
			tstart_q <= start_time;
			tstop_q  <= stop_time;
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign slot_given   = given_q;
	assign active_count = 5'(total_q);

endmodule
`default_nettype wire
